@@ rtl/mitt_pkg.sv @@
// mitt_pkg: shared types and constants for the ms interval tick timer
// holds the command codes, timer modes, transaction payloads and divider constants
// no dependencies
package mitt_pkg;

  localparam int unsigned MS_W     = 16;
  localparam int unsigned TICKS_W  = 16;
  localparam int unsigned FRAC_W   = 10;
  localparam int unsigned LEFT_W   = 22;
  localparam int unsigned QHI_W    = 10;
  localparam int unsigned RLO_W    = 7;

  localparam int unsigned FRAC_DIV = 1000;
  // 1000 = 8 * 125, the shifted ms is split as 125 * hi + lo
  localparam int unsigned SUB_DIV  = 125;

  // ms / 125 = (ms * RECIP_MUL) >> RECIP_SHIFT, exact for every 16-bit ms
  localparam logic [16:0] RECIP_MUL   = 17'd67109;
  localparam int unsigned RECIP_SHIFT = 23;

  localparam logic [TICKS_W-1:0] CHUNK_MAX = 16'hFFFF;
  localparam logic [LEFT_W-1:0]  LEFT_MAX  = 22'h3FFFFF;

  typedef enum logic [1:0] {
    OP_TICK           = 2'd0,
    OP_START_PERIODIC = 2'd1,
    OP_START_ONESHOT  = 2'd2,
    OP_STOP           = 2'd3
  } op_e;

  typedef enum logic [1:0] {
    MODE_IDLE     = 2'd0,
    MODE_PERIODIC = 2'd1,
    MODE_ONESHOT  = 2'd2
  } mode_e;

  typedef struct packed {
    logic [1:0]      op;
    logic [MS_W-1:0] interval_ms;
  } in_item_t;

  typedef struct packed {
    logic               fire;
    logic               running;
    logic               range_error;
    logic [TICKS_W-1:0] compare_ticks;
  } out_item_t;

endpackage

@@ rtl/mitt_in_if.sv @@
// mitt_in_if: command channel of the ms interval tick timer
// valid/ready handshake carrying one in_item_t per transaction, depends on mitt_pkg
interface mitt_in_if;
  import mitt_pkg::*;

  logic     valid;
  logic     ready;
  in_item_t data;

  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

@@ rtl/mitt_out_if.sv @@
// mitt_out_if: result channel of the ms interval tick timer
// valid/ready handshake carrying one out_item_t per transaction, depends on mitt_pkg
interface mitt_out_if;
  import mitt_pkg::*;

  logic      valid;
  logic      ready;
  out_item_t data;

  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

@@ rtl/ms_interval_tick_timer_top.sv @@
// ms interval tick timer: periodic and one-shot ms timer counting 2^TICK_SHIFT Hz ticks
// path: an accepted command passes the input, ms/125 and conversion registers, then the output register
// throughput: one transaction per cycle while out_o.ready takes results; a three-register ms-to-ticks conversion pipe
//   (reciprocal multiply, remainder table) feeds a combinational next-state update
// reset: asynchronous, clears all timer state and pipeline valids, no clearing pass
// depends on mitt_pkg, mitt_in_if, mitt_out_if
module ms_interval_tick_timer_top #(
  parameter int unsigned TICK_SHIFT    = 15,
  parameter int unsigned MAX_PERIOD_MS = 2000
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  mitt_in_if.sink     in_i,
  mitt_out_if.source  out_o
);
  import mitt_pkg::*;

  localparam int unsigned TSH = TICK_SHIFT - 3;
  // full quotient of (ms << TICK_SHIFT) / 1000
  localparam int unsigned QW  = TICK_SHIFT + 7;
  localparam longint unsigned PqMax =
      (64'(MAX_PERIOD_MS - 1) << TICK_SHIFT) / FRAC_DIV;
  localparam int unsigned PQW = $clog2(PqMax + 2);
  localparam int unsigned SW  = (PQW + 1 > TICKS_W) ? PQW + 1 : TICKS_W;
  localparam int unsigned XW  = (QW > LEFT_W) ? QW : LEFT_W;

  // pipeline flow control
  logic adv_o, en3, en2, en1, take3;

  // stage 1: input register
  logic            v1_q;
  op_e             op1_q;
  logic [MS_W-1:0] ms1_q;

  // stage 2: ms / 125
  logic             v2_q;
  op_e              op2_q;
  logic [MS_W-1:0]  ms2_q;
  logic [QHI_W-1:0] a2_q;
  logic             bad2_q;

  // stage 3: converted ticks and remainder
  logic              v3_q;
  op_e               op3_q;
  logic              bad3_q;
  logic [QW-1:0]     d3_q;
  logic [FRAC_W-1:0] rem3_q;

  // output register
  logic      vo_q;
  out_item_t out_q;

  // timer state
  mode_e              mode_q, mode_d;
  logic [TICKS_W-1:0] elapsed_q, elapsed_d;
  logic [TICKS_W-1:0] interval_q, interval_d;
  logic [PQW-1:0]     pq_q, pq_d;
  logic [FRAC_W-1:0]  pr_q, pr_d;
  logic [FRAC_W-1:0]  fraction_q, fraction_d;
  logic [LEFT_W-1:0]  left_q, left_d;

  logic fire_d, err_d, running_d;
  logic [TICKS_W-1:0] compare_d;

  assign adv_o = !vo_q || out_o.ready;
  assign en3   = !v3_q || adv_o;
  assign en2   = !v2_q || en3;
  assign en1   = !v1_q || en2;
  assign take3 = v3_q && adv_o;

  assign in_i.ready  = en1;
  assign out_o.valid = vo_q;
  assign out_o.data  = out_q;

  // ---------------- conversion pipe ----------------

  logic [32:0]      prod1;
  logic [QHI_W-1:0] a1;
  logic             bad1;

  assign prod1 = 33'(ms1_q) * 33'(RECIP_MUL);
  assign a1    = prod1[RECIP_SHIFT +: QHI_W];
  assign bad1  = ms1_q >= MS_W'(MAX_PERIOD_MS);

  // lo * 2^(TICK_SHIFT-3) split into quotient and remainder by 125
  logic [TSH-1:0]   tq_tbl [2**RLO_W];
  logic [RLO_W-1:0] tr_tbl [2**RLO_W];

  for (genvar g = 0; g < 2**RLO_W; g++) begin : g_tbl
    localparam int unsigned ProdVal = g << TSH;
    localparam int unsigned QuoVal  = ProdVal / SUB_DIV;
    localparam int unsigned RemVal  = ProdVal % SUB_DIV;
    assign tq_tbl[g] = TSH'(QuoVal);
    assign tr_tbl[g] = RLO_W'(RemVal);
  end

  logic [MS_W-1:0]   r_full2;
  logic [RLO_W-1:0]  r2;
  logic [QW-1:0]     d2;
  logic [FRAC_W-1:0] rem2;

  assign r_full2 = ms2_q - MS_W'(a2_q) * MS_W'(SUB_DIV);
  assign r2      = r_full2[RLO_W-1:0];
  assign d2      = (QW'(a2_q) << TSH) + QW'(tq_tbl[r2]);
  assign rem2    = {tr_tbl[r2], 3'b000};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0;
      v2_q <= 1'b0;
      v3_q <= 1'b0;
      vo_q <= 1'b0;
    end else begin
      if (en1) begin
        v1_q <= in_i.valid;
      end
      if (en2) begin
        v2_q <= v1_q;
      end
      if (en3) begin
        v3_q <= v2_q;
      end
      if (adv_o) begin
        vo_q <= v3_q;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (en1) begin
      op1_q <= op_e'(in_i.data.op);
      ms1_q <= in_i.data.interval_ms;
    end
    if (en2) begin
      op2_q  <= op1_q;
      ms2_q  <= ms1_q;
      a2_q   <= a1;
      bad2_q <= bad1;
    end
    if (en3) begin
      op3_q  <= op2_q;
      bad3_q <= bad2_q;
      d3_q   <= d2;
      rem3_q <= rem2;
    end
    if (take3) begin
      out_q.fire          <= fire_d;
      out_q.running       <= running_d;
      out_q.range_error   <= err_d;
      out_q.compare_ticks <= compare_d;
    end
  end

  // ---------------- state update ----------------

  // periodic reload: carry the remainder into the next interval
  logic [FRAC_W:0]    frac_sum;
  logic               frac_carry;
  logic [FRAC_W-1:0]  frac_next;
  logic [SW-1:0]      per_sum;
  logic [TICKS_W-1:0] per_ivl;
  logic [TICKS_W-1:0] start_ivl;

  assign frac_sum   = (FRAC_W + 1)'(pr_q) + (FRAC_W + 1)'(fraction_q);
  assign frac_carry = frac_sum >= (FRAC_W + 1)'(FRAC_DIV);
  assign frac_next  = frac_carry ? FRAC_W'(frac_sum - (FRAC_W + 1)'(FRAC_DIV))
                                 : frac_sum[FRAC_W-1:0];
  assign per_sum    = SW'(pq_q) + SW'(frac_carry);
  assign per_ivl    = (per_sum > SW'(CHUNK_MAX)) ? CHUNK_MAX : per_sum[TICKS_W-1:0];
  assign start_ivl  = (d3_q > QW'(CHUNK_MAX)) ? CHUNK_MAX : d3_q[TICKS_W-1:0];

  // one-shot total and chunking
  logic [XW-1:0]      d_ext;
  logic [LEFT_W-1:0]  os_total;
  logic [TICKS_W-1:0] os_first;
  logic [TICKS_W-1:0] os_chunk;

  assign d_ext    = XW'(d3_q);
  assign os_total = (d_ext > XW'(LEFT_MAX)) ? LEFT_MAX : d_ext[LEFT_W-1:0];
  assign os_first = (os_total > LEFT_W'(CHUNK_MAX)) ? CHUNK_MAX
                                                    : os_total[TICKS_W-1:0];
  assign os_chunk = (left_q > LEFT_W'(CHUNK_MAX)) ? CHUNK_MAX : left_q[TICKS_W-1:0];

  logic [TICKS_W:0] elapsed_inc;
  logic             hit;

  assign elapsed_inc = (TICKS_W + 1)'(elapsed_q) + (TICKS_W + 1)'(1);
  assign hit         = elapsed_inc >= (TICKS_W + 1)'(interval_q);

  // next state
  always_comb begin
    mode_d     = mode_q;
    elapsed_d  = elapsed_q;
    interval_d = interval_q;
    pq_d       = pq_q;
    pr_d       = pr_q;
    fraction_d = fraction_q;
    left_d     = left_q;
    fire_d     = 1'b0;
    err_d      = 1'b0;
    case (op3_q)
      OP_START_PERIODIC: begin
        if (bad3_q) begin
          err_d = 1'b1;
        end else begin
          mode_d     = MODE_PERIODIC;
          pq_d       = d3_q[PQW-1:0];
          pr_d       = rem3_q;
          fraction_d = rem3_q;
          elapsed_d  = '0;
          interval_d = start_ivl;
        end
      end
      OP_START_ONESHOT: begin
        mode_d     = MODE_ONESHOT;
        elapsed_d  = '0;
        interval_d = os_first;
        left_d     = os_total - LEFT_W'(os_first);
      end
      OP_STOP: begin
        mode_d    = MODE_IDLE;
        elapsed_d = '0;
      end
      OP_TICK: begin
        if (mode_q == MODE_PERIODIC || mode_q == MODE_ONESHOT) begin
          if (hit) begin
            elapsed_d = '0;
            if (mode_q == MODE_PERIODIC) begin
              fire_d     = 1'b1;
              interval_d = per_ivl;
              fraction_d = frac_next;
            end else if (left_q != '0) begin
              interval_d = os_chunk;
              left_d     = left_q - LEFT_W'(os_chunk);
            end else begin
              fire_d = 1'b1;
              mode_d = MODE_IDLE;
            end
          end else begin
            elapsed_d = elapsed_inc[TICKS_W-1:0];
          end
        end
      end
    endcase
  end

  // result fields
  always_comb begin
    running_d = (mode_d == MODE_PERIODIC) || (mode_d == MODE_ONESHOT);
    compare_d = running_d ? interval_d : '0;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q     <= MODE_IDLE;
      elapsed_q  <= '0;
      interval_q <= '0;
      pq_q       <= '0;
      pr_q       <= '0;
      fraction_q <= '0;
      left_q     <= '0;
    end else if (take3) begin
      mode_q     <= mode_d;
      elapsed_q  <= elapsed_d;
      interval_q <= interval_d;
      pq_q       <= pq_d;
      pr_q       <= pr_d;
      fraction_q <= fraction_d;
      left_q     <= left_d;
    end
  end

  // ---------------- assertions ----------------

  // a rejected periodic start leaves the running count untouched
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    take3 && op3_q == OP_START_PERIODIC && bad3_q
    |=> $stable(mode_q) && $stable(elapsed_q) && $stable(interval_q))
    else $error("rejected periodic start changed timer state");

  // the running count never passes its compare value
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (mode_q == MODE_PERIODIC || mode_q == MODE_ONESHOT)
    |-> (elapsed_q < interval_q) || (elapsed_q == '0))
    else $error("elapsed count beyond interval");

  // only a tick can raise an event
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    take3 && op3_q != OP_TICK |=> !out_q.fire)
    else $error("event raised by a non-tick command");

  // carried remainder stays a valid fraction of 1000
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    take3 && mode_d == MODE_PERIODIC |=> fraction_q < FRAC_W'(FRAC_DIV))
    else $error("periodic remainder out of range");

  // the command side only stalls when a result is held back
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    !in_i.ready |-> vo_q && !out_o.ready)
    else $error("command side stalled with room in the pipe");

endmodule
